>>> src/mpse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mpse_pkg;

	// command codes carried in tuser
	localparam logic [1:0] CMD_REPORT = 2'd0;
	localparam logic [1:0] CMD_LOAD   = 2'd1;
	localparam logic [1:0] CMD_SHIFT  = 2'd2;

	// register indexes, taken from paddr[2]
	localparam logic REG_POS_LOW  = 1'b0;
	localparam logic REG_POS_HIGH = 1'b1;

	localparam int POS_W   = 9;
	localparam int DIV_W   = 4;
	localparam int MOT_W   = 8;
	localparam int BTN_W   = 3;
	localparam int SUM_W   = 11;
	localparam int DATA_BIT = 8;

	localparam logic [POS_W-1:0] POS_RESET  = 9'd236;
	localparam logic [POS_W-1:0] LOW_RESET  = 9'd151;
	localparam logic [POS_W-1:0] HIGH_RESET = 9'd309;
	localparam logic [DIV_W-1:0] DIV_RESET  = 4'd6;
	localparam logic [DIV_W-1:0] DIV_MAX    = 4'd10;
	localparam logic [DIV_W-1:0] DIV_WRAP   = 4'd4;
	localparam logic [DIV_W-1:0] DIV_STEP   = 4'd2;

	localparam logic [BTN_W-1:0] BTN_MIDDLE  = 3'b100;
	localparam logic [BTN_W-1:0] BTN_TRIGGER = 3'b011;

	localparam logic [2:0] DIV_LAST = 3'd7;

	typedef struct packed {
		logic start;
		logic div_step;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_busy;
	} dp_stat_t;

endpackage
`default_nettype wire

>>> src/mpse_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mpse_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [1:0]             command,
	input  wire mpse_pkg::dp_stat_t     stat,
	output mpse_pkg::ctrl_cmd_t         cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DIV    = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		cmd.start    = 1'b0;
		cmd.div_step = 1'b0;
		cmd.commit   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.start = 1'b1;
					state_d = (command == mpse_pkg::CMD_REPORT) ? ST_DIV : ST_COMMIT;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				// hold until the output register is free
				if (!stat.out_busy) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

>>> src/mpse_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module mpse_dpath #(
	parameter int SHIFT_BITS = 9
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mpse_pkg::ctrl_cmd_t           cmd,
	input  wire logic [1:0]                    command,
	input  wire logic [mpse_pkg::BTN_W-1:0]    buttons,
	input  wire logic [mpse_pkg::MOT_W-1:0]    motion_x,
	input  wire logic [mpse_pkg::POS_W-1:0]    position_low,
	input  wire logic [mpse_pkg::POS_W-1:0]    position_high,
	input  wire logic                          m_tready,
	output logic                               m_tvalid,
	output logic [15:0]                        m_tdata,
	output mpse_pkg::dp_stat_t                 stat
);

	logic [mpse_pkg::POS_W-1:0] position_q;
	logic [mpse_pkg::DIV_W-1:0] divisor_q;
	logic                       middle_q;
	logic                       trigger_q;
	logic [SHIFT_BITS-1:0]      shift_q;

	logic [1:0]                 command_q;
	logic                       neg_q;
	logic [mpse_pkg::MOT_W-1:0] quo_q;
	logic [mpse_pkg::DIV_W-1:0] rem_q;
	logic [2:0]                 cnt_q;

	logic                       out_valid_q;
	logic [15:0]                out_data_q;

	logic [mpse_pkg::MOT_W-1:0] mag;
	logic [mpse_pkg::DIV_W:0]   rem_sh;
	logic                       fits;
	logic [mpse_pkg::SUM_W-1:0] step;
	logic signed [mpse_pkg::SUM_W-1:0] sum;
	logic signed [mpse_pkg::SUM_W-1:0] lo_ext;
	logic signed [mpse_pkg::SUM_W-1:0] hi_ext;
	logic [mpse_pkg::POS_W-1:0] pos_next;
	logic [SHIFT_BITS-1:0]      shift_next;
	logic                       mid;
	logic [mpse_pkg::DIV_W-1:0] div_next;

	// magnitude of the motion; -128 comes out as 0x80
	assign mag    = motion_x[mpse_pkg::MOT_W-1] ? (~motion_x + 8'd1) : motion_x;
	assign mid    = (buttons & mpse_pkg::BTN_MIDDLE) != '0;
	assign div_next = (divisor_q < mpse_pkg::DIV_WRAP) ? mpse_pkg::DIV_MAX
		: divisor_q - mpse_pkg::DIV_STEP;

	// one restoring divide step per cycle, msb first
	assign rem_sh = {rem_q, quo_q[mpse_pkg::MOT_W-1]};
	assign fits   = rem_sh >= {1'b0, divisor_q};

	assign step   = neg_q ? (~{3'b000, quo_q} + 11'd1) : {3'b000, quo_q};
	assign sum    = signed'({2'b00, position_q} + step);
	assign lo_ext = signed'({2'b00, position_low});
	assign hi_ext = signed'({2'b00, position_high});

	always_comb begin
		pos_next   = position_q;
		shift_next = shift_q;
		case (command_q)
			mpse_pkg::CMD_REPORT: begin
				// upper clamp checked first; the upper clamp wins when the bounds are inverted
				if (sum > hi_ext) begin
					pos_next = position_high;
				end else if (sum < lo_ext) begin
					pos_next = (lo_ext > hi_ext) ? position_high : position_low;
				end else begin
					pos_next = sum[mpse_pkg::POS_W-1:0];
				end
			end
			mpse_pkg::CMD_LOAD: begin
				shift_next = SHIFT_BITS'(position_q);
			end
			mpse_pkg::CMD_SHIFT: begin
				shift_next = {shift_q[SHIFT_BITS-2:0], 1'b0};
			end
			default: begin
				pos_next   = position_q;
				shift_next = shift_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q  <= mpse_pkg::POS_RESET;
			divisor_q   <= mpse_pkg::DIV_RESET;
			middle_q    <= 1'b0;
			trigger_q   <= 1'b0;
			shift_q     <= '0;
			out_valid_q <= 1'b0;
			command_q   <= mpse_pkg::CMD_REPORT;
			cnt_q       <= '0;
		end else begin
			if (cmd.start) begin
				command_q <= command;
				cnt_q     <= '0;
				if (command == mpse_pkg::CMD_REPORT) begin
					if (mid && !middle_q) begin
						divisor_q <= div_next;
					end
					middle_q  <= mid;
					trigger_q <= (buttons & mpse_pkg::BTN_TRIGGER) != '0;
				end
			end
			if (cmd.div_step) begin
				cnt_q <= cnt_q + 3'd1;
			end
			if (cmd.commit) begin
				position_q  <= pos_next;
				shift_q     <= shift_next;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			neg_q <= motion_x[mpse_pkg::MOT_W-1];
			quo_q <= mag;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= fits ? mpse_pkg::DIV_W'(rem_sh - {1'b0, divisor_q})
				: rem_sh[mpse_pkg::DIV_W-1:0];
			quo_q <= {quo_q[mpse_pkg::MOT_W-2:0], fits};
		end
		if (cmd.commit) begin
			out_data_q <= {1'b0, divisor_q, pos_next, trigger_q,
				shift_next[mpse_pkg::DATA_BIT]};
		end
	end

	assign stat.div_done = cnt_q == mpse_pkg::DIV_LAST;
	assign stat.out_busy = out_valid_q && !m_tready;
	assign m_tvalid      = out_valid_q;
	assign m_tdata       = out_data_q;

endmodule
`default_nettype wire

>>> src/mouse_to_paddle_serial_encoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Mouse to paddle encoder. Each input word carries a command in s_tuser: a mouse
// report (buttons and signed x motion in s_tdata), a load strobe or a shift clock
// strobe. Every word gives exactly one output word with the serial data level,
// trigger state, paddle position and current divisor, all as they stand after
// that word. For a report, the x motion is divided by a bit-serial restoring
// divider, one quotient bit per cycle for the eight quotient bits, then clamped
// and committed to the output register. Load, shift and unused commands go
// straight to the commit. The next word is accepted only after the previous
// one is committed, but also while the previous output word still waits; the
// commit waits only if the output register is still full.
// Bounds are written at byte addresses 0 (low) and 4 (high); the user must
// write them only while idle, as the block does not enforce it.
module mouse_to_paddle_serial_encoder_top #(
	parameter int SHIFT_BITS = 9
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // buttons[2:0], motion_x[10:3], zero
	input  wire logic [1:0]  s_tuser,   // command[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // data_level, trigger_pressed, paddle_position,
	                                    // divisor_now, zero
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [mpse_pkg::POS_W-1:0] pos_low_q;
	logic [mpse_pkg::POS_W-1:0] pos_high_q;
	logic                       cfg_wr;
	mpse_pkg::ctrl_cmd_t        cmd;
	mpse_pkg::dp_stat_t         stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_low_q  <= mpse_pkg::LOW_RESET;
			pos_high_q <= mpse_pkg::HIGH_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == mpse_pkg::REG_POS_LOW) begin
				pos_low_q <= pwdata[mpse_pkg::POS_W-1:0];
			end else begin
				pos_high_q <= pwdata[mpse_pkg::POS_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == mpse_pkg::REG_POS_HIGH) ? {23'd0, pos_high_q}
		: {23'd0, pos_low_q};

	mpse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.command  (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	mpse_dpath #(
		.SHIFT_BITS (SHIFT_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.command       (s_tuser),
		.buttons       (s_tdata[2:0]),
		.motion_x      (s_tdata[10:3]),
		.position_low  (pos_low_q),
		.position_high (pos_high_q),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.m_tdata       (m_tdata),
		.stat          (stat)
	);

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
module tb;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [1:0]                 cmd;
		logic [mpse_pkg::BTN_W-1:0] buttons;
		logic [mpse_pkg::MOT_W-1:0] motion;
	} paddle_word_t;

	typedef struct packed {
		logic                       data_level;
		logic                       trigger;
		logic [mpse_pkg::POS_W-1:0] position;
		logic [mpse_pkg::DIV_W-1:0] divisor;
	} paddle_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	wire         s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	wire         m_tvalid;
	logic        m_tready = 1'b0;
	wire  [15:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire  [31:0] prdata;
	wire         pready;

	mouse_to_paddle_serial_encoder_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #2 clk = ~clk;

	// paddle model state and bounds
	logic [mpse_pkg::POS_W-1:0] bound_low = mpse_pkg::LOW_RESET;
	logic [mpse_pkg::POS_W-1:0] bound_high = mpse_pkg::HIGH_RESET;
	logic [mpse_pkg::POS_W-1:0] paddle_pos = mpse_pkg::POS_RESET;
	logic [mpse_pkg::DIV_W-1:0] paddle_div = mpse_pkg::DIV_RESET;
	logic                       middle_held = 1'b0;
	logic                       trigger_held = 1'b0;
	logic [8:0]                 serial_reg = '0;

	paddle_word_t  pending_words[$];
	paddle_state_t expected_states[$];
	paddle_word_t  word_on_bus;
	paddle_state_t seen_state;
	paddle_state_t want_state;
	bit            steady = 1'b0;
	int            errors = 0;
	int            cycles = 0;

	function automatic paddle_state_t advance_paddle(input paddle_word_t w);
		int            sum;
		paddle_state_t r;
		case (w.cmd)
			mpse_pkg::CMD_REPORT: begin
				if (!middle_held && (w.buttons & mpse_pkg::BTN_MIDDLE) != 0)
					paddle_div = (paddle_div < mpse_pkg::DIV_WRAP) ? mpse_pkg::DIV_MAX
						: paddle_div - mpse_pkg::DIV_STEP;
				middle_held = (w.buttons & mpse_pkg::BTN_MIDDLE) != 0;
				trigger_held = (w.buttons & mpse_pkg::BTN_TRIGGER) != 0;
				// int division truncates toward zero
				sum = int'(paddle_pos) + int'($signed(w.motion)) / int'(paddle_div);
				if (sum < int'(bound_low))
					sum = int'(bound_low);
				if (sum > int'(bound_high))
					sum = int'(bound_high);
				paddle_pos = sum[mpse_pkg::POS_W-1:0];
			end
			mpse_pkg::CMD_LOAD: serial_reg = paddle_pos;
			mpse_pkg::CMD_SHIFT: serial_reg = serial_reg << 1;
			default: ;
		endcase
		r.data_level = serial_reg[mpse_pkg::DATA_BIT];
		r.trigger = trigger_held;
		r.position = paddle_pos;
		r.divisor = paddle_div;
		return r;
	endfunction

	function automatic paddle_word_t make_word(input logic [1:0] cmd, input logic [2:0] btn,
			input logic [7:0] mot);
		paddle_word_t w;
		w.cmd = cmd;
		w.buttons = btn;
		w.motion = mot;
		return w;
	endfunction

	function automatic paddle_word_t random_word(input logic [1:0] cmd);
		logic [7:0] mot;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 6)
			mot = 8'h80;
		else if (pick < 12)
			mot = 8'h7f;
		else
			mot = 8'($urandom_range(255));
		return make_word(cmd, 3'($urandom_range(7)), mot);
	endfunction

	// source side: one word held until taken, random gaps between words unless steady
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready)
				expected_states.push_back(advance_paddle(word_on_bus));
			if (!s_tvalid || s_tready) begin
				if (pending_words.size() != 0 && (steady || $urandom_range(99) >= 29)) begin
					word_on_bus = pending_words.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {5'b0, word_on_bus.motion, word_on_bus.buttons};
					s_tuser <= word_on_bus.cmd;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// sink side: check each word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen_state.data_level = m_tdata[0];
				seen_state.trigger = m_tdata[1];
				seen_state.position = m_tdata[10:2];
				seen_state.divisor = m_tdata[14:11];
				if (expected_states.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("unexpected output word %h", m_tdata);
				end else begin
					want_state = expected_states.pop_front();
					if (seen_state.data_level !== want_state.data_level ||
							seen_state.trigger !== want_state.trigger ||
							seen_state.position !== want_state.position ||
							seen_state.divisor !== want_state.divisor) begin
						errors++;
						if (errors <= REPORT_LIMIT)
							$display("mismatch: exp lvl %b trig %b pos %0d div %0d, ",
								want_state.data_level, want_state.trigger,
								want_state.position, want_state.divisor,
								"got lvl %b trig %b pos %0d div %0d",
								seen_state.data_level, seen_state.trigger,
								seen_state.position, seen_state.divisor);
					end
				end
			end
			m_tready <= steady || ($urandom_range(99) >= 29);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	task automatic settle();
		while (pending_words.size() != 0 || expected_states.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [8:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {23'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_bounds(input logic [8:0] lo, input logic [8:0] hi);
		settle();
		apb_write({mpse_pkg::REG_POS_LOW, 2'b00}, lo);
		bound_low = lo;
		apb_write({mpse_pkg::REG_POS_HIGH, 2'b00}, hi);
		bound_high = hi;
	endtask

	// mostly report bursts followed by a load and a run of shifts, some noise
	task automatic queue_frames(input int n);
		int done;
		int k;
		int pick;
		done = 0;
		while (done < n) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				pending_words.push_back(random_word(2'($urandom_range(3))));
				done++;
			end else begin
				k = $urandom_range(1, 6);
				repeat (k) pending_words.push_back(random_word(mpse_pkg::CMD_REPORT));
				done += k;
				if (pick < 85) begin
					pending_words.push_back(random_word(mpse_pkg::CMD_LOAD));
					k = $urandom_range(0, 10);
					repeat (k) pending_words.push_back(random_word(mpse_pkg::CMD_SHIFT));
					done += k + 1;
				end
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of motion, the whole divisor cycle, trigger buttons, strobes
		pending_words.push_back(make_word(mpse_pkg::CMD_REPORT, 3'b000, 8'h7f));
		pending_words.push_back(make_word(mpse_pkg::CMD_REPORT, 3'b000, 8'h80));
		pending_words.push_back(make_word(mpse_pkg::CMD_REPORT, 3'b000, 8'h00));
		pending_words.push_back(make_word(mpse_pkg::CMD_REPORT, 3'b100, 8'hf9));
		pending_words.push_back(make_word(mpse_pkg::CMD_REPORT, 3'b100, 8'h05));
		pending_words.push_back(make_word(mpse_pkg::CMD_REPORT, 3'b000, 8'hff));
		pending_words.push_back(make_word(mpse_pkg::CMD_REPORT, 3'b100, 8'h64));
		pending_words.push_back(make_word(mpse_pkg::CMD_REPORT, 3'b000, 8'h00));
		pending_words.push_back(make_word(mpse_pkg::CMD_REPORT, 3'b100, 8'h80));
		pending_words.push_back(make_word(mpse_pkg::CMD_REPORT, 3'b001, 8'h00));
		pending_words.push_back(make_word(mpse_pkg::CMD_REPORT, 3'b101, 8'h7f));
		pending_words.push_back(make_word(mpse_pkg::CMD_REPORT, 3'b010, 8'h9c));
		pending_words.push_back(make_word(mpse_pkg::CMD_REPORT, 3'b110, 8'h09));
		pending_words.push_back(make_word(mpse_pkg::CMD_REPORT, 3'b011, 8'h01));
		// some strobes and the unused command carry junk in the data fields
		pending_words.push_back(make_word(mpse_pkg::CMD_LOAD, 3'b111, 8'h80));
		pending_words.push_back(make_word(mpse_pkg::CMD_SHIFT, 3'b111, 8'h7f));
		pending_words.push_back(make_word(CMD_UNUSED, 3'b101, 8'hff));
		pending_words.push_back(make_word(mpse_pkg::CMD_SHIFT, 3'b000, 8'h00));
		pending_words.push_back(make_word(mpse_pkg::CMD_REPORT, 3'b000, 8'h7f));
		pending_words.push_back(make_word(mpse_pkg::CMD_REPORT, 3'b000, 8'h7f));
		pending_words.push_back(make_word(mpse_pkg::CMD_LOAD, 3'b000, 8'h00));
		pending_words.push_back(make_word(mpse_pkg::CMD_SHIFT, 3'b000, 8'h00));
		pending_words.push_back(make_word(CMD_UNUSED, 3'b010, 8'h80));
		queue_frames(230);

		set_bounds(9'd0, 9'd511);
		queue_frames(350);

		// inverted bounds: upper clamp wins
		set_bounds(9'd400, 9'd100);
		queue_frames(250);

		set_bounds(9'd0, 9'd0);
		queue_frames(150);
		set_bounds(9'd511, 9'd511);
		queue_frames(150);

		set_bounds(9'd100, 9'd450);
		steady = 1'b1;
		queue_frames(300);
		settle();
		steady = 1'b0;

		repeat (3) begin
			set_bounds(9'($urandom_range(511)), 9'($urandom_range(511)));
			queue_frames(150);
		end

		settle();
		if (errors == 0 && expected_states.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

>>> mouse_to_paddle_serial_encoder_top.f
src/mpse_pkg.sv
src/mpse_ctrl.sv
src/mpse_dpath.sv
src/mouse_to_paddle_serial_encoder_top.sv
dv/tb.sv
